// ----- rtl/core/nir_pkg.sv -----
// Shared types, widths and constants of the NEC infrared pulse decoder.
package nir_pkg;

   localparam int CAPTURE_W  = 14;
   localparam int KEY_W      = 8;
   localparam int SHIFT_W    = 16;
   localparam int BITS_W     = 6;
   localparam int TICKS_W    = 4;
   localparam int REPEATS_W  = 8;
   localparam int NUM_REGS   = 8;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      ITEM_TICK    = 1'b0,
      ITEM_CAPTURE = 1'b1
   } item_kind_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_ZERO_LOW    = 3'd0,
      REG_ZERO_HIGH   = 3'd1,
      REG_ONE_LOW     = 3'd2,
      REG_ONE_HIGH    = 3'd3,
      REG_REPEAT_LOW  = 3'd4,
      REG_REPEAT_HIGH = 3'd5,
      REG_LEADER_LOW  = 3'd6,
      REG_LEADER_HIGH = 3'd7
   } reg_index_type;

   typedef logic [CAPTURE_W-1:0]                width_type;
   typedef logic [NUM_REGS-1:0][CAPTURE_W-1:0] band_regs_type;

   // Register reset values, highest index first.
   localparam band_regs_type BAND_RESET = {
      14'd4700, 14'd4200, 14'd2500, 14'd2100,
      14'd1800, 14'd1400, 14'd800,  14'd300
   };

   // Bit counts that check the frame, latch the key or emit a key.
   localparam logic [BITS_W-1:0] BITS_ADDR_CHECK  = 6'd16;
   localparam logic [BITS_W-1:0] BITS_DATA_LATCH  = 6'd24;
   localparam logic [BITS_W-1:0] BITS_DATA_CHECK  = 6'd32;
   localparam logic [BITS_W-1:0] BITS_FRAME_DONE  = 6'd33;
   localparam logic [BITS_W-1:0] BITS_REPEAT_EMIT = 6'd34;

   localparam logic [TICKS_W-1:0]   TICKS_SHORT    = 4'd3;
   localparam logic [TICKS_W-1:0]   TICKS_LONG     = 4'd9;
   localparam logic [TICKS_W-1:0]   TICKS_MAX      = 4'd15;
   localparam logic [REPEATS_W-1:0] REPEATS_IGNORE = 8'd3;
   localparam logic [REPEATS_W-1:0] REPEATS_MAX    = 8'd255;

endpackage

// ----- rtl/core/nir_req_if.sv -----
// Input channel of the decoder: timer ticks and edge captures.
interface nir_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [nir_pkg::CAPTURE_W-1:0] capture_count;

   modport source (output valid, req_type, capture_count, input ready);
   modport sink (input valid, req_type, capture_count, output ready);
endinterface

// ----- rtl/core/nir_rsp_if.sv -----
// Result channel of the decoder: decoded keys.
interface nir_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [nir_pkg::KEY_W-1:0] key_code;
   logic                     is_repeat;
   logic                     frame_ok;

   modport source (output valid, key_code, is_repeat, frame_ok, input ready);
   modport sink (input valid, key_code, is_repeat, frame_ok, output ready);
endinterface

// ----- rtl/core/nir_csr.sv -----
// APB-style register file holding the pulse width bands.
module nir_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [nir_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [nir_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [nir_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output nir_pkg::band_regs_type            bands
);

   nir_pkg::band_regs_type              bands_ff;
   nir_pkg::band_regs_type              bands_in;
   logic [nir_pkg::REG_IDX_W-1:0]       reg_idx;

   assign reg_idx    = csr_paddr[nir_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign bands      = bands_ff;

   always_comb begin
      bands_in = bands_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         bands_in[reg_idx] = csr_pwdata[nir_pkg::CAPTURE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bands_ff <= nir_pkg::BAND_RESET;
      end else begin
         bands_ff <= bands_in;
      end
   end

   assign csr_prdata = {{(nir_pkg::CSR_DATA_W - nir_pkg::CAPTURE_W){1'b0}}, bands_ff[reg_idx]};

endmodule

// ----- rtl/core/nec_ir_pulse_decoder.sv -----
// Top level of the NEC infrared pulse decoder.
//
// The req_bus channel carries one item per transfer: a 10 ms timer tick or an
// edge capture with the microsecond count of the pulse. Captures alternate;
// the first one restarts pulse timing and the second one is classed by the
// band registers as a leader, a bit zero, a bit one or a repeat code.
// A completed frame, and after it each further bit or each repeat past the
// first four, produces one transfer on rsp_bus with the key byte and its flags.
// The csr_ port is an APB-style register file of eight 14-bit band bounds
// at byte addresses 0 to 28; writes are expected only while the block idles.
// An accepted item is held in an input register and worked from there; its
// result, if any, lands in the output register. One item is accepted in
// every cycle while the output register is free or drains to the receiver.
// While the receiver stalls, the output register keeps its result and the
// input register holds the next item, so at most one further item is taken.
// Synchronous reset restores the band defaults, empties both registers and
// returns the decoder to waiting for a leader.
module nec_ir_pulse_decoder (
   input  logic                           clock,
   input  logic                           reset,
   nir_req_if.sink                        req_bus,
   nir_rsp_if.source                      rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [nir_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [nir_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [nir_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   nir_pkg::band_regs_type bands;

   nir_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .bands       (bands)
   );

   // Input register.
   logic                          in_valid_ff, in_valid_in;
   logic                          in_kind_ff;
   logic [nir_pkg::CAPTURE_W-1:0] in_count_ff;

   // Decoder state.
   logic                           phase_ff, phase_in;
   logic                           active_ff, active_in;
   logic [nir_pkg::TICKS_W-1:0]    ticks_ff, ticks_in;
   logic [nir_pkg::SHIFT_W-1:0]    shift_ff, shift_in;
   logic [nir_pkg::BITS_W-1:0]     bits_ff, bits_in;
   logic [nir_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [nir_pkg::REPEATS_W-1:0]  repeats_ff, repeats_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [nir_pkg::KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic                      rsp_repeat_ff, rsp_repeat_in;
   logic                      rsp_ok_ff, rsp_ok_in;

   logic advance;
   logic work;
   logic emit;

   // The worked item moves on whenever the output register is free or drains.
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign work          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   function automatic logic in_band(input nir_pkg::width_type w,
                                    input nir_pkg::width_type lo,
                                    input nir_pkg::width_type hi);
      in_band = (w > lo) && (w < hi);
   endfunction

   always_comb begin
      logic [nir_pkg::SHIFT_W-1:0] shift_mid;
      logic [nir_pkg::BITS_W-1:0]  bits_mid;
      logic                        data_ok;

      phase_in   = phase_ff;
      active_in  = active_ff;
      ticks_in   = ticks_ff;
      shift_in   = shift_ff;
      bits_in    = bits_ff;
      key_in     = key_ff;
      repeats_in = repeats_ff;
      emit       = 1'b0;
      rsp_key_in    = key_ff;
      rsp_repeat_in = 1'b0;
      rsp_ok_in     = 1'b0;
      shift_mid  = shift_ff;
      bits_mid   = bits_ff;
      data_ok    = 1'b0;

      if (work) begin
         if (in_kind_ff == nir_pkg::ITEM_TICK) begin
            // A quiet line ends the frame; repeats stretch the allowed gap.
            if (active_ff) begin
               if ((ticks_ff > nir_pkg::TICKS_SHORT) &&
                   ((repeats_ff == '0) || (ticks_ff > nir_pkg::TICKS_LONG))) begin
                  active_in = 1'b0;
               end
               if (ticks_ff < nir_pkg::TICKS_MAX) begin
                  ticks_in = ticks_ff + 1'b1;
               end
            end
         end else if (!phase_ff) begin
            phase_in = 1'b1;
            ticks_in = '0;
         end else begin
            phase_in = 1'b0;
            if (active_ff) begin
               priority if (in_band(in_count_ff, bands[nir_pkg::REG_ZERO_LOW],
                                    bands[nir_pkg::REG_ZERO_HIGH])) begin
                  shift_mid = {shift_ff[nir_pkg::SHIFT_W-2:0], 1'b0};
                  bits_mid  = bits_ff + 1'b1;
               end else if (in_band(in_count_ff, bands[nir_pkg::REG_ONE_LOW],
                                    bands[nir_pkg::REG_ONE_HIGH])) begin
                  shift_mid = {shift_ff[nir_pkg::SHIFT_W-2:0], 1'b1};
                  bits_mid  = bits_ff + 1'b1;
               end else if (in_band(in_count_ff, bands[nir_pkg::REG_REPEAT_LOW],
                                    bands[nir_pkg::REG_REPEAT_HIGH])) begin
                  if (repeats_ff > nir_pkg::REPEATS_IGNORE) begin
                     bits_mid = bits_ff + 1'b1;
                  end
                  if (repeats_ff < nir_pkg::REPEATS_MAX) begin
                     repeats_in = repeats_ff + 1'b1;
                  end
               end else begin
               end
            end else if (in_band(in_count_ff, bands[nir_pkg::REG_LEADER_LOW],
                                 bands[nir_pkg::REG_LEADER_HIGH])) begin
               active_in  = 1'b1;
               bits_mid   = '0;
               repeats_in = '0;
            end

            shift_in = shift_mid;
            bits_in  = bits_mid;

            // Frame checkpoints, evaluated on the updated bit count.
            if (bits_mid == nir_pkg::BITS_ADDR_CHECK) begin
               if (shift_mid[nir_pkg::SHIFT_W-1:nir_pkg::KEY_W] !=
                   ~shift_mid[nir_pkg::KEY_W-1:0]) begin
                  bits_in   = '0;
                  active_in = 1'b0;
               end
               shift_in = '0;
            end else if (bits_mid == nir_pkg::BITS_DATA_LATCH) begin
               key_in   = shift_mid[nir_pkg::KEY_W-1:0];
               shift_in = '0;
            end else if (bits_mid == nir_pkg::BITS_DATA_CHECK) begin
               data_ok  = (key_ff == ~shift_mid[nir_pkg::KEY_W-1:0]);
               key_in   = data_ok ? key_ff : '0;
               shift_in = '0;
               bits_in  = nir_pkg::BITS_FRAME_DONE;
               emit          = 1'b1;
               rsp_key_in    = key_in;
               rsp_repeat_in = 1'b0;
               rsp_ok_in     = data_ok;
            end else if (bits_mid == nir_pkg::BITS_REPEAT_EMIT) begin
               // After a frame, a bit or a repeat past four replays the key.
               bits_in       = nir_pkg::BITS_FRAME_DONE;
               emit          = 1'b1;
               rsp_key_in    = key_ff;
               rsp_repeat_in = 1'b1;
               rsp_ok_in     = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = work && emit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         active_ff    <= 1'b0;
         ticks_ff     <= '0;
         shift_ff     <= '0;
         bits_ff      <= '0;
         key_ff       <= '0;
         repeats_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         ticks_ff     <= ticks_in;
         shift_ff     <= shift_in;
         bits_ff      <= bits_in;
         key_ff       <= key_in;
         repeats_ff   <= repeats_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_kind_ff  <= req_bus.req_type;
         in_count_ff <= req_bus.capture_count;
      end
      if (work && emit) begin
         rsp_key_ff    <= rsp_key_in;
         rsp_repeat_ff <= rsp_repeat_in;
         rsp_ok_ff     <= rsp_ok_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.key_code  = rsp_key_ff;
   assign rsp_bus.is_repeat = rsp_repeat_ff;
   assign rsp_bus.frame_ok  = rsp_ok_ff;

endmodule

// ----- tb/nir_key_check.sv -----
// Key predictor and result checker for the NEC infrared pulse decoder.
module nir_key_check
   import nir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   nir_req_if                    req_mon,
   nir_rsp_if                    rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    fail_count,
   output int                    keys_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [KEY_W-1:0] key_code;
      logic             is_repeat;
      logic             frame_ok;
   } key_result_type;

   key_result_type expected_keys[$];

   // Decoder state as seen by the predictor.
   band_regs_type          bands;
   logic                   capture_armed;
   logic                   frame_active;
   logic [TICKS_W-1:0]     tick_count;
   logic [SHIFT_W-1:0]     shift_data;
   logic [BITS_W-1:0]      bit_count;
   logic [KEY_W-1:0]       stored_key;
   logic [REPEATS_W-1:0]   repeat_count;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic bit in_band(input width_type w, input reg_index_type lo_reg);
      return w > bands[lo_reg] && w < bands[int'(lo_reg) + 1];
   endfunction

   task automatic decode_item(input item_kind_type kind, input width_type cnt);
      key_result_type res;
      bit             emit;
      emit = 1'b0;
      res  = '0;
      if (kind == ITEM_TICK) begin
         if (frame_active) begin
            if (tick_count > TICKS_SHORT &&
                (repeat_count == 0 || tick_count > TICKS_LONG))
               frame_active = 1'b0;
            if (tick_count < TICKS_MAX) tick_count++;
         end
         return;
      end
      // The first capture of a pair only restarts the pulse timing.
      if (!capture_armed) begin
         capture_armed = 1'b1;
         tick_count    = '0;
         return;
      end
      capture_armed = 1'b0;
      if (frame_active) begin
         if (in_band(cnt, REG_ZERO_LOW)) begin
            shift_data = {shift_data[SHIFT_W-2:0], 1'b0};
            bit_count++;
         end else if (in_band(cnt, REG_ONE_LOW)) begin
            shift_data = {shift_data[SHIFT_W-2:0], 1'b1};
            bit_count++;
         end else if (in_band(cnt, REG_REPEAT_LOW)) begin
            if (repeat_count > REPEATS_IGNORE) bit_count++;
            if (repeat_count < REPEATS_MAX) repeat_count++;
         end
      end else if (in_band(cnt, REG_LEADER_LOW)) begin
         frame_active = 1'b1;
         bit_count    = '0;
         repeat_count = '0;
      end
      case (bit_count)
         BITS_ADDR_CHECK: begin
            if (shift_data[15:8] != ~shift_data[7:0]) begin
               bit_count    = '0;
               frame_active = 1'b0;
            end
            shift_data = '0;
         end
         BITS_DATA_LATCH: begin
            stored_key = shift_data[7:0];
            shift_data = '0;
         end
         BITS_DATA_CHECK: begin
            res.frame_ok = (stored_key == ~shift_data[7:0]);
            if (!res.frame_ok) stored_key = '0;
            shift_data    = '0;
            bit_count     = BITS_FRAME_DONE;
            res.key_code  = stored_key;
            res.is_repeat = 1'b0;
            emit          = 1'b1;
         end
         BITS_REPEAT_EMIT: begin
            bit_count     = BITS_FRAME_DONE;
            res.key_code  = stored_key;
            res.is_repeat = 1'b1;
            res.frame_ok  = 1'b1;
            emit          = 1'b1;
         end
         default: ;
      endcase
      if (emit) expected_keys.push_back(res);
   endtask

   always @(posedge clock) begin
      key_result_type want;
      if (reset) begin
         bands         = BAND_RESET;
         capture_armed = 1'b0;
         frame_active  = 1'b0;
         tick_count    = '0;
         shift_data    = '0;
         bit_count     = '0;
         stored_key    = '0;
         repeat_count  = '0;
         expected_keys.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_keys.size() == 0) begin
               report_mismatch($sformatf("key %0h arrived with nothing expected",
                                         rsp_mon.key_code));
            end else begin
               want = expected_keys.pop_front();
               if (rsp_mon.key_code !== want.key_code)
                  report_mismatch($sformatf("key_code %0h, expected %0h",
                                            rsp_mon.key_code, want.key_code));
               if (rsp_mon.is_repeat !== want.is_repeat)
                  report_mismatch($sformatf("is_repeat %b, expected %b",
                                            rsp_mon.is_repeat, want.is_repeat));
               if (rsp_mon.frame_ok !== want.frame_ok)
                  report_mismatch($sformatf("frame_ok %b, expected %b",
                                            rsp_mon.frame_ok, want.frame_ok));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            bands[csr_paddr[CSR_ADDR_W-1:2]] = csr_pwdata[CAPTURE_W-1:0];
         if (req_mon.valid && req_mon.ready)
            decode_item(item_kind_type'(req_mon.req_type), req_mon.capture_count);
      end
      keys_pending = expected_keys.size();
   end

endmodule

// ----- tb/tb_nec_ir_pulse_decoder.sv -----
// Top level of the NEC infrared pulse decoder testbench: stimulus and verdict.
module tb_nec_ir_pulse_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import nir_pkg::*;

   // Room for a result to follow its item, with slack for any stall.
   localparam int DRAIN_CYCLES   = 4;
   // Cycles without any transfer before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int FIELD_MAX      = 10000;

   // Bands that reach both ends of the stimulus range, zero and FIELD_MAX.
   localparam band_regs_type EXTREME_BANDS = {
      14'd10000, 14'd2700, 14'd2600, 14'd1600,
      14'd1500,  14'd700,  14'd600,  14'd0
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    fail_count;
   int                    keys_pending;
   int                    quiet_cycles;

   // Stimulus bookkeeping. The band copy lets the generator aim its pulse
   // widths at the classes that the block is currently configured for.
   int                    tx_idle_pct;
   int                    rx_idle_pct;
   int                    items_sent;
   bit                    capture_odd;
   band_regs_type         cur_bands;

   nir_req_if req_bus ();
   nir_rsp_if rsp_bus ();

   nec_ir_pulse_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   nir_key_check key_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_pready   (csr_pready),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .fail_count   (fail_count),
      .keys_pending (keys_pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // The receiver stalls at random with the percentage that the current phase
   // sets; with a percentage of zero it takes every result at once.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // The watchdog restarts on every transfer on either channel. Only a hung
   // block, or one that never delivers an expected key, lets it run out.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One item per call. The sender may idle first; valid then stays high
   // until the transfer, and is left high so that back-to-back items need no
   // second assignment in the same time step.
   task automatic send_item(input item_kind_type kind, input width_type cnt);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= kind;
      req_bus.capture_count <= cnt;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (kind == ITEM_CAPTURE) capture_odd = !capture_odd;
   endtask

   // A pulse is a pair of captures: the first carries a count that the block
   // ignores, the second carries the measured width.
   task automatic pulse(input width_type w);
      send_item(ITEM_CAPTURE, width_type'($urandom_range(0, FIELD_MAX)));
      send_item(ITEM_CAPTURE, w);
   endtask

   task automatic send_tick();
      send_item(ITEM_TICK, width_type'($urandom_range(0, FIELD_MAX)));
   endtask

   // Stray single captures leave the block waiting for a second capture. A
   // width of zero lies in no band, so it realigns the pairs harmlessly.
   task automatic align_captures();
      if (capture_odd) send_item(ITEM_CAPTURE, '0);
   endtask

   // A width inside the band that starts at the given register, often at
   // one of its edges.
   function automatic width_type width_in(input reg_index_type lo_reg);
      width_type lo;
      width_type hi;
      lo = cur_bands[lo_reg];
      hi = cur_bands[int'(lo_reg) + 1];
      case ($urandom_range(9))
         0:       return lo + 1'b1;
         1:       return hi - 1'b1;
         default: return width_type'($urandom_range(int'(lo) + 1, int'(hi) - 1));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      for (int i = 7; i >= 0; i--)
         pulse(b[i] ? width_in(REG_ONE_LOW) : width_in(REG_ZERO_LOW));
   endtask

   // Usually enough ticks to end a frame even after repeat codes; now and
   // then only enough for a frame without repeats, so that a live frame
   // swallows the next leader.
   task automatic close_frame();
      repeat (($urandom_range(5) == 0) ? 5 : 11) send_tick();
   endtask

   // A complete frame: leader, address, inverse address, key and inverse
   // key, then perhaps stray bits after the frame and a train of repeats.
   task automatic run_frame(input int repeats);
      logic [7:0] addr;
      logic [7:0] key;
      logic [7:0] addr_inv;
      logic [7:0] key_inv;
      addr     = 8'($urandom);
      key      = 8'($urandom);
      addr_inv = ~addr;
      key_inv  = ~key;
      if ($urandom_range(9) == 0) addr_inv = addr_inv ^ (8'd1 << $urandom_range(7));
      if ($urandom_range(6) == 0) key_inv = key_inv ^ (8'd1 << $urandom_range(7));
      align_captures();
      pulse(width_in(REG_LEADER_LOW));
      send_byte(addr);
      send_byte(addr_inv);
      send_byte(key);
      send_byte(key_inv);
      repeat ($urandom_range(0, 2))
         pulse(width_in($urandom_range(1) ? REG_ONE_LOW : REG_ZERO_LOW));
      repeat (repeats) begin
         if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send_tick();
         pulse(width_in(REG_REPEAT_LOW));
      end
   endtask

   // A leader followed by pulses of any class, including leaders and widths
   // that fall in no band.
   task automatic run_broken_frame();
      align_captures();
      pulse(width_in(REG_LEADER_LOW));
      repeat ($urandom_range(1, 40)) begin
         case ($urandom_range(4))
            0:       pulse(width_in(REG_ZERO_LOW));
            1:       pulse(width_in(REG_ONE_LOW));
            2:       pulse(width_in(REG_REPEAT_LOW));
            3:       pulse(width_in(REG_LEADER_LOW));
            default: pulse(width_type'($urandom_range(0, FIELD_MAX)));
         endcase
      end
   endtask

   // Unstructured items: ticks and lone captures of any count.
   task automatic run_noise();
      repeat ($urandom_range(8, 24)) begin
         if ($urandom_range(2) == 0) send_tick();
         else send_item(ITEM_CAPTURE, width_type'($urandom_range(0, FIELD_MAX)));
      end
   endtask

   // Mostly well-formed frames with random content, the rest noise and
   // broken frames.
   task automatic run_traffic(input int item_goal);
      int goal_end;
      goal_end = items_sent + item_goal;
      while (items_sent < goal_end) begin
         close_frame();
         case ($urandom_range(9))
            0:       run_noise();
            1:       run_broken_frame();
            default: run_frame($urandom_range(0, 12));
         endcase
      end
   endtask

   // Lets every expected key arrive, then gives an item that produced no key
   // time to leave the block before the registers change.
   task automatic drain_keys();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (keys_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the data at the edge
   // that ends the access cycle. The select stays high so that a following
   // write starts its setup cycle at once; apply_bands releases it.
   task automatic write_reg(input reg_index_type idx, input width_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cur_bands[idx] = value;
   endtask

   task automatic apply_bands(input band_regs_type b);
      for (int i = 0; i < NUM_REGS; i++) write_reg(reg_index_type'(i), b[i]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Ordered, non-overlapping bands at random places; each band is at least
   // two counts wide so that it holds a width.
   function automatic band_regs_type random_bands();
      band_regs_type b;
      int            mark;
      mark = $urandom_range(0, 400);
      for (int i = 0; i < NUM_REGS; i++) begin
         b[i] = width_type'(mark);
         mark += $urandom_range((i % 2 == 0) ? 3 : 0, 1200);
      end
      return b;
   endfunction

   // Bounds in any order: bands overlap, are empty or are inverted.
   function automatic band_regs_type loose_bands();
      band_regs_type b;
      for (int i = 0; i < NUM_REGS; i++) b[i] = width_type'($urandom_range(0, FIELD_MAX));
      return b;
   endfunction

   initial begin
      int goal_end;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.req_type      = ITEM_TICK;
      req_bus.capture_count = '0;
      rsp_bus.ready         = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      tx_idle_pct           = 13;
      rx_idle_pct           = 87;
      items_sent            = 0;
      capture_odd           = 1'b0;
      cur_bands             = BAND_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset bands. A tick while idle does nothing;
      // widths at the exclusive bounds and at the field's extremes fall in
      // no band; a leader starts a frame and a second leader inside it is
      // ignored; then one bit of each kind and a repeat that is counted but
      // not yet answered, and a single tick, too few to end the frame.
      send_tick();
      pulse('0);
      pulse(width_type'(FIELD_MAX));
      pulse(14'd4200);
      pulse(14'd4700);
      pulse(14'd4201);
      pulse(14'd4699);
      pulse(14'd301);
      pulse(14'd800);
      pulse(14'd1400);
      pulse(14'd1401);
      pulse(14'd2100);
      pulse(14'd2101);
      send_tick();

      // First phase: the sender seldom idles and the receiver mostly stalls.
      run_traffic(100);
      drain_keys();

      // Second phase: the other way round, with bands at random places.
      tx_idle_pct = 87;
      rx_idle_pct <= 13;
      apply_bands(random_bands());
      run_traffic(100);
      drain_keys();

      // Third phase: no idling at all. Bands touch both ends of the range,
      // and one long train of repeats drives the repeat counter into
      // saturation.
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      apply_bands(EXTREME_BANDS);
      run_traffic(30);
      close_frame();
      run_frame(260);
      drain_keys();

      // Overlapping and inverted bands, fed with noise and broken frames.
      apply_bands(loose_bands());
      goal_end = items_sent + 50;
      while (items_sent < goal_end) begin
         if ($urandom_range(1) == 0) run_noise();
         else run_broken_frame();
      end
      drain_keys();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/nir_pkg.sv
rtl/core/nir_req_if.sv
rtl/core/nir_rsp_if.sv
rtl/core/nir_csr.sv
rtl/core/nec_ir_pulse_decoder.sv
tb/nir_key_check.sv
tb/tb_nec_ir_pulse_decoder.sv
